/* rtl/npic_pkg.sv */
// ----------------------------------------------------------------------------
// npic_pkg
// Shared widths, request codes and controller/datapath handshake types for
// the nested priority interrupt controller.
// ----------------------------------------------------------------------------
`default_nettype none

package npic_pkg;

  // Fixed field widths
  localparam int unsigned REQ_W       = 3;
  localparam int unsigned LINE_W      = 3;
  localparam int unsigned LVL_W       = 9;
  localparam int unsigned PEND_W      = 8;
  localparam int unsigned RLINE_W     = 4;
  localparam int unsigned CFG_W       = 64;
  localparam int unsigned PRIO_STRIDE = 8;

  // Level and line values with special meaning
  localparam logic [LVL_W-1:0]   THREAD_LEVEL = 9'd256;
  localparam logic [RLINE_W-1:0] NO_LINE      = 4'd8;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_PEND     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ENABLE   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_DISABLE  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_MASK_SET = 3'd3;
  localparam logic [REQ_W-1:0] REQ_MASK_CLR = 3'd4;
  localparam logic [REQ_W-1:0] REQ_RETURN   = 3'd5;
  localparam logic [REQ_W-1:0] REQ_DISPATCH = 3'd6;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic latch;     // input beat accepted, capture it
    logic exec;      // apply the request
    logic pick;      // select and possibly take a line
    logic load_out;  // move the result into the output register
  } npic_cmd_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic need_pick; // request goes on to line selection
    logic out_free;  // output register can take a result this cycle
  } npic_stat_t;

endpackage

`default_nettype wire

/* rtl/npic_req_if.sv */
// ----------------------------------------------------------------------------
// npic_req_if
// Request channel: one interrupt event per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface npic_req_if;
  logic                           valid;
  logic                           ready;
  logic [npic_pkg::REQ_W-1:0]     req_type;
  logic [npic_pkg::LINE_W-1:0]    irq_num;

  modport source (output valid, output req_type, output irq_num, input ready);
  modport sink   (input valid, input req_type, input irq_num, output ready);
endinterface

`default_nettype wire

/* rtl/npic_rsp_if.sv */
// ----------------------------------------------------------------------------
// npic_rsp_if
// Result channel: one result beat per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface npic_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           taken_valid;
  logic [npic_pkg::LINE_W-1:0]    taken_irq;
  logic [npic_pkg::LVL_W-1:0]     current_level;
  logic [npic_pkg::PEND_W-1:0]    pending_mask;
  logic                           return_ignored;

  modport source (output valid, output taken_valid, output taken_irq,
                  output current_level, output pending_mask,
                  output return_ignored, input ready);
  modport sink   (input valid, input taken_valid, input taken_irq,
                  input current_level, input pending_mask,
                  input return_ignored, output ready);
endinterface

`default_nettype wire

/* rtl/nested_priority_interrupt_controller_top.sv */
// ----------------------------------------------------------------------------
// nested_priority_interrupt_controller_top
// Nested priority interrupt controller with pending/enable bits, global mask
// and a context stack for preemption.
// ----------------------------------------------------------------------------
// One request beat in gives one result beat out. A request is accepted only
// while the sequencer is idle. Pend, enable, disable, mask, unused codes and
// a handler return with nothing active go from the apply state to the done
// state, which loads the result into the output register. Dispatch, and a
// handler return that pops a context, pass through the pick state between
// them for the selection over all lines. The sequencer goes back to idle as
// the result is loaded; no new request is accepted before that. A result
// that is not taken holds the sequencer before the load, stalling the next
// request after the one in flight. The user writes the priority register
// (cfg_we_i/cfg_wdata_i) only while idle; the block does not enforce this.
`default_nettype none

module nested_priority_interrupt_controller_top #(
  parameter int unsigned IRQ_COUNT  = 8,
  parameter int unsigned PRIO_BITS  = 8,
  parameter int unsigned NEST_DEPTH = 8
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [npic_pkg::CFG_W-1:0]    cfg_wdata_i,
  npic_req_if.sink                     req_i,
  npic_rsp_if.source                   rsp_o
);

  npic_pkg::npic_cmd_t  cmd;
  npic_pkg::npic_stat_t stat;
  logic                 in_ready;

  assign req_i.ready = in_ready;

  // Sequencer
  npic_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // State, selection and output register
  npic_datapath #(
    .IRQ_COUNT  (IRQ_COUNT),
    .PRIO_BITS  (PRIO_BITS),
    .NEST_DEPTH (NEST_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_type_i  (req_i.req_type),
    .irq_num_i   (req_i.irq_num),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .rsp         (rsp_o)
  );

endmodule

`default_nettype wire

/* rtl/npic_ctrl.sv */
// ----------------------------------------------------------------------------
// npic_ctrl
// Sequencer: accept, apply, select, then hand the result to the output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module npic_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  npic_pkg::npic_stat_t stat_i,
  output npic_pkg::npic_cmd_t  cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_PICK = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = stat_i.need_pick ? ST_PICK : ST_DONE;
      end
      ST_PICK: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Commands
  assign in_ready_o     = (state_q == ST_IDLE);
  assign cmd_o.latch    = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.exec     = (state_q == ST_EXEC);
  assign cmd_o.pick     = (state_q == ST_PICK);
  assign cmd_o.load_out = (state_q == ST_DONE) && stat_i.out_free;

endmodule

`default_nettype wire

/* rtl/npic_datapath.sv */
// ----------------------------------------------------------------------------
// npic_datapath
// Pending/enable bits, mask, active context, nesting stack, line selection
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module npic_datapath #(
  parameter int unsigned IRQ_COUNT  = 8,
  parameter int unsigned PRIO_BITS  = 8,
  parameter int unsigned NEST_DEPTH = 8
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire [npic_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  wire [npic_pkg::REQ_W-1:0]          req_type_i,
  input  wire [npic_pkg::LINE_W-1:0]         irq_num_i,
  input  npic_pkg::npic_cmd_t                cmd_i,
  output npic_pkg::npic_stat_t               stat_o,
  npic_rsp_if.source                         rsp
);

  localparam int unsigned LVL_W   = npic_pkg::LVL_W;
  localparam int unsigned LINE_W  = npic_pkg::LINE_W;
  localparam int unsigned RLINE_W = npic_pkg::RLINE_W;
  localparam int unsigned CNT_W   = $clog2(NEST_DEPTH + 1);
  localparam int unsigned IDX_W   = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

  typedef struct packed {
    logic [RLINE_W-1:0] line;
    logic [LVL_W-1:0]   level;
  } ctx_t;

  // Configuration
  logic [npic_pkg::CFG_W-1:0] prio_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prio_q <= '0;
    end else if (cfg_we_i) begin
      prio_q <= cfg_wdata_i;
    end
  end

  // Controller state
  logic [IRQ_COUNT-1:0] pending_q, pending_d;
  logic [IRQ_COUNT-1:0] enabled_q, enabled_d;
  logic                 mask_q, mask_d;
  logic [LVL_W-1:0]     level_q, level_d;
  logic [RLINE_W-1:0]   line_q, line_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 taken_q, taken_d;
  logic [LINE_W-1:0]    taken_line_q, taken_line_d;
  logic                 ignored_q, ignored_d;
  logic                 out_valid_q, out_valid_d;

  // Captured request and stack read data
  logic [npic_pkg::REQ_W-1:0] req_q;
  logic [LINE_W-1:0]          irq_q;
  ctx_t                       stack_mem [NEST_DEPTH];
  ctx_t                       stack_rd_q;

  logic [IDX_W-1:0] push_idx, pop_idx;
  assign push_idx = IDX_W'(cnt_q);
  assign pop_idx  = IDX_W'(cnt_q - CNT_W'(1));

  // Line selection: lowest priority value, lowest index on a tie
  logic                 found;
  logic [LINE_W-1:0]    best;
  logic [PRIO_BITS-1:0] best_prio;
  logic [IRQ_COUNT-1:0] cand;
  logic                 take;

  assign cand = pending_q & enabled_q;

  always_comb begin
    found     = 1'b0;
    best      = '0;
    best_prio = '0;
    for (int i = 0; i < IRQ_COUNT; i++) begin
      if (cand[i] && (!found ||
          prio_q[i*npic_pkg::PRIO_STRIDE +: PRIO_BITS] < best_prio)) begin
        found     = 1'b1;
        best      = LINE_W'(i);
        best_prio = prio_q[i*npic_pkg::PRIO_STRIDE +: PRIO_BITS];
      end
    end
  end

  assign take = !mask_q && found && (LVL_W'(best_prio) < level_q) &&
                (cnt_q < CNT_W'(NEST_DEPTH));

  logic                 line_ok;
  logic [IRQ_COUNT-1:0] irq_bit;
  logic [IRQ_COUNT-1:0] best_bit;
  assign line_ok  = ({1'b0, irq_q} < (LINE_W+1)'(IRQ_COUNT));
  assign irq_bit  = IRQ_COUNT'(1) << irq_q;
  assign best_bit = IRQ_COUNT'(1) << best;

  // Request handling and take
  always_comb begin
    pending_d    = pending_q;
    enabled_d    = enabled_q;
    mask_d       = mask_q;
    level_d      = level_q;
    line_d       = line_q;
    cnt_d        = cnt_q;
    taken_d      = taken_q;
    taken_line_d = taken_line_q;
    ignored_d    = ignored_q;

    if (cmd_i.exec) begin
      taken_d      = 1'b0;
      taken_line_d = '0;
      ignored_d    = 1'b0;
      case (req_q)
        npic_pkg::REQ_PEND: begin
          if (line_ok) pending_d = pending_q | irq_bit;
        end
        npic_pkg::REQ_ENABLE: begin
          if (line_ok) enabled_d = enabled_q | irq_bit;
        end
        npic_pkg::REQ_DISABLE: begin
          if (line_ok) enabled_d = enabled_q & ~irq_bit;
        end
        npic_pkg::REQ_MASK_SET: begin
          mask_d = 1'b1;
        end
        npic_pkg::REQ_MASK_CLR: begin
          mask_d = 1'b0;
        end
        npic_pkg::REQ_RETURN: begin
          if (cnt_q == '0) begin
            ignored_d = 1'b1;
          end else begin
            cnt_d   = cnt_q - CNT_W'(1);
            level_d = stack_rd_q.level;
            line_d  = stack_rd_q.line;
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.pick && take) begin
      pending_d    = pending_q & ~best_bit;
      cnt_d        = cnt_q + CNT_W'(1);
      level_d      = LVL_W'(best_prio);
      line_d       = RLINE_W'(best);
      taken_d      = 1'b1;
      taken_line_d = best;
    end
  end

  // Output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (rsp.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q    <= '0;
      enabled_q    <= '0;
      mask_q       <= 1'b0;
      level_q      <= npic_pkg::THREAD_LEVEL;
      line_q       <= npic_pkg::NO_LINE;
      cnt_q        <= '0;
      taken_q      <= 1'b0;
      taken_line_q <= '0;
      ignored_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pending_q    <= pending_d;
      enabled_q    <= enabled_d;
      mask_q       <= mask_d;
      level_q      <= level_d;
      line_q       <= line_d;
      cnt_q        <= cnt_d;
      taken_q      <= taken_d;
      taken_line_q <= taken_line_d;
      ignored_q    <= ignored_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Request capture and stack top read, done while the count is stable
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q      <= req_type_i;
      irq_q      <= irq_num_i;
      stack_rd_q <= stack_mem[pop_idx];
    end
  end

  // Stack push on take
  always_ff @(posedge clk_i) begin
    if (cmd_i.pick && take) begin
      stack_mem[push_idx] <= '{line: line_q, level: level_q};
    end
  end

  // Output payload register
  logic [LINE_W-1:0]          out_irq_q;
  logic                       out_taken_q;
  logic [LVL_W-1:0]           out_level_q;
  logic [npic_pkg::PEND_W-1:0] out_pend_q;
  logic                       out_ign_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_taken_q <= taken_q;
      out_irq_q   <= taken_line_q;
      out_level_q <= level_q;
      out_pend_q  <= npic_pkg::PEND_W'(pending_q);
      out_ign_q   <= ignored_q;
    end
  end

  assign rsp.valid          = out_valid_q;
  assign rsp.taken_valid    = out_taken_q;
  assign rsp.taken_irq      = out_irq_q;
  assign rsp.current_level  = out_level_q;
  assign rsp.pending_mask   = out_pend_q;
  assign rsp.return_ignored = out_ign_q;

  // Status to the sequencer
  assign stat_o.need_pick = (req_q == npic_pkg::REQ_DISPATCH) ||
                            ((req_q == npic_pkg::REQ_RETURN) && (cnt_q != '0));
  assign stat_o.out_free  = !out_valid_q || rsp.ready;

  // Assertions
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(NEST_DEPTH))
    else $error("nesting count above stack depth");

  a_thread_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (level_q == npic_pkg::THREAD_LEVEL))
    else $error("empty stack but not at thread level");

  a_take_lowers_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.pick && take) |=> (level_q < $past(level_q)))
    else $error("take did not raise the active priority");

  a_taken_xor_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_taken_q && out_ign_q))
    else $error("result both taken and return ignored");

endmodule

`default_nettype wire

/* test/npic_checker.sv */
// ----------------------------------------------------------------------------
// npic_checker
// Watches the request, result and priority-write ports of the nested priority
// interrupt controller. It keeps its own copy of the pending, enable, mask and
// nesting state, predicts the result of every accepted request beat, and
// compares each result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module npic_checker
  import npic_pkg::*;
#(
  parameter int unsigned NUM_LINES   = 8,
  parameter int unsigned PRIO_W      = 8,
  parameter int unsigned STACK_DEPTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  npic_req_if              req_mon_i,
  npic_rsp_if              rsp_mon_i,
  output int unsigned      err_count_o,
  output int unsigned      outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned       MAX_REPORTS = 200;
  localparam int unsigned       CTX_W       = LVL_W + RLINE_W;
  localparam logic [PEND_W-1:0] LINE_MASK   = PEND_W'((1 << NUM_LINES) - 1);
  localparam logic [PRIO_STRIDE-1:0] PRIO_MASK = PRIO_STRIDE'((1 << PRIO_W) - 1);

  typedef struct packed {
    logic              taken_valid;
    logic [LINE_W-1:0] taken_irq;
    logic [LVL_W-1:0]  level;
    logic [PEND_W-1:0] pending;
    logic              ret_ignored;
  } irq_outcome_t;

  // Shadow controller state
  logic [CFG_W-1:0]   prio_reg;
  logic [PEND_W-1:0]  pend_bits;
  logic [PEND_W-1:0]  enab_bits;
  logic               mask_bit;
  logic [LVL_W-1:0]   act_level;
  logic [RLINE_W-1:0] run_line;
  logic [CTX_W-1:0]   ctx_stack [STACK_DEPTH];
  int unsigned        ctx_depth;

  irq_outcome_t outcome_q [$];
  int unsigned  n_wait  = 0;
  int unsigned  err_cnt = 0;

  assign err_count_o   = err_cnt;
  assign outstanding_o = n_wait;

  // Effective priority of one line, zero-extended to level width
  function automatic logic [LVL_W-1:0] line_prio(int unsigned ln);
    logic [PRIO_STRIDE-1:0] raw;
    raw = prio_reg[ln*PRIO_STRIDE +: PRIO_STRIDE];
    return LVL_W'(raw & PRIO_MASK);
  endfunction

  // Pick the best pending enabled line and take it if it preempts
  task automatic try_preempt(output logic took, output logic [LINE_W-1:0] ln);
    logic [PEND_W-1:0] cand;
    int unsigned       best;
    logic              found;
    took  = 1'b0;
    ln    = '0;
    best  = 0;
    found = 1'b0;
    cand  = pend_bits & enab_bits & LINE_MASK;
    if (!mask_bit && cand != '0) begin
      for (int unsigned i = 0; i < NUM_LINES; i++) begin
        if (cand[i] && (!found || line_prio(i) < line_prio(best))) begin
          best  = i;
          found = 1'b1;
        end
      end
      // strict preemption, and only while the stack has room
      if (line_prio(best) < act_level && ctx_depth < STACK_DEPTH) begin
        pend_bits[best]      = 1'b0;
        ctx_stack[ctx_depth] = {run_line, act_level};
        ctx_depth++;
        act_level = line_prio(best);
        run_line  = RLINE_W'(best);
        took      = 1'b1;
        ln        = LINE_W'(best);
      end
    end
  endtask

  // Apply one request to the shadow state and form its result
  task automatic predict_event(input logic [REQ_W-1:0] rt, input logic [LINE_W-1:0] irq,
                               output irq_outcome_t res);
    logic              took;
    logic [LINE_W-1:0] ln;
    took = 1'b0;
    ln   = '0;
    res  = '0;
    case (rt)
      REQ_PEND:     if (irq < NUM_LINES) pend_bits[irq] = 1'b1;
      REQ_ENABLE:   if (irq < NUM_LINES) enab_bits[irq] = 1'b1;
      REQ_DISABLE:  if (irq < NUM_LINES) enab_bits[irq] = 1'b0;
      REQ_MASK_SET: mask_bit = 1'b1;
      REQ_MASK_CLR: mask_bit = 1'b0;
      REQ_RETURN: begin
        if (ctx_depth == 0) begin
          res.ret_ignored = 1'b1;
        end else begin
          // pop, then tail-chain into the next line if one preempts
          ctx_depth--;
          {run_line, act_level} = ctx_stack[ctx_depth];
          try_preempt(took, ln);
        end
      end
      REQ_DISPATCH: try_preempt(took, ln);
      default: ;
    endcase
    res.taken_valid = took;
    res.taken_irq   = took ? ln : '0;
    res.level       = act_level;
    res.pending     = pend_bits;
  endtask

  task automatic check_field(string fname, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      err_cnt++;
      if (err_cnt <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
    end
  endtask

  // Monitor: results first, then priority writes, then new request beats
  always @(posedge clk_i or negedge rst_ni) begin
    irq_outcome_t want;
    irq_outcome_t pred;
    if (!rst_ni) begin
      prio_reg  = '0;
      pend_bits = '0;
      enab_bits = '0;
      mask_bit  = 1'b0;
      act_level = THREAD_LEVEL;
      run_line  = NO_LINE;
      ctx_depth = 0;
      for (int unsigned i = 0; i < STACK_DEPTH; i++) ctx_stack[i] = '0;
      outcome_q.delete();
      n_wait = 0;
    end else begin
      if (rsp_mon_i.valid && rsp_mon_i.ready) begin
        if (outcome_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("%0t: result beat with nothing expected, actual taken=%0h irq=%0h %s%0h %s%0h %s%0h",
                     $time, rsp_mon_i.taken_valid, rsp_mon_i.taken_irq,
                     "level=", rsp_mon_i.current_level, "pending=", rsp_mon_i.pending_mask,
                     "ignored=", rsp_mon_i.return_ignored);
        end else begin
          want = outcome_q.pop_front();
          check_field("taken_valid", 16'(want.taken_valid), 16'(rsp_mon_i.taken_valid));
          check_field("taken_irq", 16'(want.taken_irq), 16'(rsp_mon_i.taken_irq));
          check_field("current_level", 16'(want.level), 16'(rsp_mon_i.current_level));
          check_field("pending_mask", 16'(want.pending), 16'(rsp_mon_i.pending_mask));
          check_field("return_ignored", 16'(want.ret_ignored), 16'(rsp_mon_i.return_ignored));
        end
      end
      if (cfg_we_i) prio_reg = cfg_wdata_i;
      if (req_mon_i.valid && req_mon_i.ready) begin
        predict_event(req_mon_i.req_type, req_mon_i.irq_num, pred);
        outcome_q.push_back(pred);
      end
      n_wait = outcome_q.size();
    end
  end

endmodule

/* test/nested_priority_interrupt_controller_top_tb.sv */
// ----------------------------------------------------------------------------
// nested_priority_interrupt_controller_top_tb
// Drives interrupt events into the controller: a short directed sequence for
// masking, enabling, preemption, tail chaining and ignored returns, then
// phases under several priority settings, each with a deep nesting run and
// weighted random events. Both channels idle at random; the result side also
// holds off for a long stretch to back the block up. The checker scores.
// ----------------------------------------------------------------------------
module nested_priority_interrupt_controller_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import npic_pkg::*;

  localparam int unsigned NUM_LINES   = 8;
  localparam int unsigned NEST_DEPTH  = 8;
  localparam int unsigned CYCLE_LIMIT = 800000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned BURST_LEN   = 40;
  localparam int unsigned SETTLE_CYC  = 8;
  localparam int unsigned TAIL_CYC    = 20;
  localparam int unsigned PHASE_ITEMS = 170;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  int unsigned err_count;
  int unsigned outstanding;

  // sender-side flags, written right after a rising edge
  bit          steady       = 1'b0;
  bit          hold_off_req = 1'b0;
  bit          want_hold    = 1'b0;
  int unsigned burst_left   = 0;

  npic_req_if req_if ();
  npic_rsp_if rsp_if ();

  nested_priority_interrupt_controller_top #(
    .IRQ_COUNT (NUM_LINES),
    .PRIO_BITS (8),
    .NEST_DEPTH(NEST_DEPTH)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  npic_checker #(
    .NUM_LINES  (NUM_LINES),
    .PRIO_W     (8),
    .STACK_DEPTH(NEST_DEPTH)
  ) u_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .req_mon_i    (req_if),
    .rsp_mon_i    (rsp_if),
    .err_count_o  (err_count),
    .outstanding_o(outstanding)
  );

  always #1 clk = ~clk;

  // Idle length: mostly short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // One request beat; returns just after the accepting edge
  task automatic send_beat(logic [REQ_W-1:0] rt, logic [LINE_W-1:0] ln);
    @(negedge clk);
    req_if.valid    = 1'b1;
    req_if.req_type = rt;
    req_if.irq_num  = ln;
    do @(posedge clk); while (!req_if.ready);
  endtask

  // Beat plus mode updates and a random gap
  task automatic send_event(logic [REQ_W-1:0] rt, logic [LINE_W-1:0] ln);
    int unsigned gap;
    send_beat(rt, ln);
    if (want_hold) begin
      want_hold    = 1'b0;
      hold_off_req = 1'b1;
      burst_left   = BURST_LEN;
    end
    if (steady ? ($urandom_range(0, 11) == 0) : ($urandom_range(0, 79) == 0))
      steady = !steady;
    if (steady || burst_left != 0) gap = 0;
    else if ($urandom_range(0, 1) == 0) gap = 0;
    else gap = idle_len();
    if (burst_left != 0) burst_left--;
    if (gap != 0) begin
      @(negedge clk);
      req_if.valid    = 1'b0;
      req_if.req_type = REQ_W'($urandom_range(0, 7));
      req_if.irq_num  = LINE_W'($urandom_range(0, 7));
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic wait_idle();
    @(negedge clk);
    req_if.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_prio(logic [CFG_W-1:0] v);
    wait_idle();
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Weighted random event, biased toward pend/dispatch/return traffic
  task automatic rand_event();
    int unsigned      r;
    logic [REQ_W-1:0] rt;
    r = $urandom_range(0, 99);
    if (r < 26)      rt = REQ_PEND;
    else if (r < 38) rt = REQ_ENABLE;
    else if (r < 43) rt = REQ_DISABLE;
    else if (r < 46) rt = REQ_MASK_SET;
    else if (r < 53) rt = REQ_MASK_CLR;
    else if (r < 73) rt = REQ_RETURN;
    else if (r < 97) rt = REQ_DISPATCH;
    else             rt = REQ_UNUSED;
    send_event(rt, LINE_W'($urandom_range(0, 7)));
  endtask

  // Nest as deep as the priorities allow, then send one return more than the stack depth
  task automatic deep_nest(logic [CFG_W-1:0] v);
    int unsigned order [NUM_LINES];
    int unsigned tmp;
    for (int unsigned i = 0; i < NUM_LINES; i++) order[i] = i;
    for (int unsigned i = 0; i < NUM_LINES; i++) begin
      for (int unsigned j = 0; j + 1 < NUM_LINES - i; j++) begin
        if (v[order[j]*8 +: 8] < v[order[j+1]*8 +: 8]) begin
          tmp        = order[j];
          order[j]   = order[j+1];
          order[j+1] = tmp;
        end
      end
    end
    send_event(REQ_MASK_CLR, LINE_W'($urandom_range(0, 7)));
    for (int unsigned i = 0; i < NUM_LINES; i++) send_event(REQ_ENABLE, LINE_W'(i));
    for (int unsigned i = 0; i < NUM_LINES; i++) begin
      send_event(REQ_PEND, LINE_W'(order[i]));
      send_event(REQ_DISPATCH, LINE_W'($urandom_range(0, 7)));
    end
    repeat (NEST_DEPTH + 1) send_event(REQ_RETURN, LINE_W'($urandom_range(0, 7)));
  endtask

  task automatic run_phase(logic [CFG_W-1:0] v, int unsigned n);
    write_prio(v);
    deep_nest(v);
    for (int unsigned i = 0; i < n; i++) begin
      if (i == n / 3) want_hold = 1'b1;
      if (i == (2 * n) / 3) wait_idle();
      rand_event();
    end
  endtask

  // Directed opening; line 0 has the highest value, line 7 the lowest
  task automatic directed_events();
    send_event(REQ_RETURN, 3'd0);    // nothing active: ignored
    send_event(REQ_DISPATCH, 3'd7);  // nothing pending
    send_event(REQ_UNUSED, 3'd5);
    send_event(REQ_PEND, 3'd0);
    send_event(REQ_DISPATCH, 3'd0);  // pending but not enabled
    send_event(REQ_ENABLE, 3'd0);
    send_event(REQ_MASK_SET, 3'd0);
    send_event(REQ_DISPATCH, 3'd0);  // masked
    send_event(REQ_MASK_CLR, 3'd0);  // no dispatch on its own
    send_event(REQ_DISPATCH, 3'd0);  // take line 0
    send_event(REQ_PEND, 3'd7);
    send_event(REQ_PEND, 3'd3);
    send_event(REQ_ENABLE, 3'd3);
    send_event(REQ_DISPATCH, 3'd0);  // line 3 preempts, 7 still disabled
    send_event(REQ_ENABLE, 3'd7);
    send_event(REQ_DISPATCH, 3'd0);  // line 7 preempts
    send_event(REQ_PEND, 3'd0);
    send_event(REQ_DISPATCH, 3'd0);  // no strict preemption
    send_event(REQ_DISABLE, 3'd0);
    send_event(REQ_RETURN, 3'd0);    // back to line 3, line 0 disabled
    send_event(REQ_ENABLE, 3'd0);
    send_event(REQ_RETURN, 3'd0);    // back to line 0, same level: no take
    send_event(REQ_RETURN, 3'd0);    // thread level, tail chain into line 0
    send_event(REQ_RETURN, 3'd0);
    send_event(REQ_RETURN, 3'd0);    // ignored again
  endtask

  // Result side: random ready, with long hold-offs on request
  initial begin : rsp_sink
    int unsigned left;
    logic        on;
    left          = 0;
    on            = 1'b0;
    rsp_if.ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        rsp_if.ready = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        left = 0;
      end else begin
        if (left == 0) begin
          if (steady || $urandom_range(0, 2) != 0) begin
            on   = 1'b1;
            left = $urandom_range(1, 16);
          end else begin
            on   = 1'b0;
            left = idle_len();
          end
        end
        rsp_if.ready = on;
        left--;
      end
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    req_if.valid    = 1'b0;
    req_if.req_type = REQ_PEND;
    req_if.irq_num  = '0;
    rst_n           = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_prio(64'h0010_2030_4050_6070);
    directed_events();
    run_phase(64'h0001_0203_0405_0607, PHASE_ITEMS);
    run_phase({CFG_W{1'b1}}, PHASE_ITEMS);
    run_phase({CFG_W{1'b0}}, PHASE_ITEMS);
    run_phase(64'h0706_0504_0302_0100, PHASE_ITEMS);
    run_phase({$urandom, $urandom}, PHASE_ITEMS);
    run_phase({$urandom, $urandom} & 64'h0303_0303_0303_0303, PHASE_ITEMS);

    wait_idle();
    repeat (TAIL_CYC) @(negedge clk);
    if (err_count == 0 && outstanding == 0) begin
      $display("nested_priority_interrupt_controller_top_tb OK");
    end else begin
      $display("nested_priority_interrupt_controller_top_tb NOT OK");
    end
    $finish;
  end

  // Cycle limit
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("nested_priority_interrupt_controller_top_tb NOT OK");
    $finish;
  end

endmodule
